// File: hw/rtl/rm2q_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies; used by every module under hw/rtl.
package rm2q_pkg;

	localparam int W  = 16;
	localparam int F  = W - 2;
	localparam int MW = W + 1;
	localparam int SW = 2 * MW + 2;
	localparam int RW = MW + 1;
	localparam int NW = W + F + 2;
	localparam int QW = F + 1;
	localparam logic [W-1:0] ONE = W'(1) << F;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	typedef struct packed {
		logic [3:0][MW-1:0] mag;
		logic [3:0]         neg;
		branch_t            branch;
		logic               rpos;
	} side_t;

endpackage

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Stages: 3 front, 18 root and 17 divide/output stages, all registered.
// Throughput: one matrix per cycle; the whole pipeline holds while m_tvalid && !m_tready.
// A waiting result holds every stage and drops s_tready until it is taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on rm2q_pkg, rm2q_prep, rm2q_sqrt and rm2q_div.
module rotation_matrix_to_quaternion (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// quat_w, quat_x, quat_y, quat_z (16 bits each)
	output logic [63:0]  m_tdata,
	// branch_taken [1:0], degenerate [2]
	output logic [2:0]   m_tuser
);
	import rm2q_pkg::*;

	logic              adv;
	logic [8:0][W-1:0] m;
	logic              v_a, v_b;
	side_t             side_a, side_b;
	logic [SW-1:0]     sumsq;
	logic [RW-1:0]     norm;
	logic [3:0][W-1:0] quat;
	branch_t           branch;
	logic              degenerate;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = s_tdata[i*W +: W];
		end
	end

	rm2q_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.m         (m),
		.out_valid (v_a),
		.side      (side_a),
		.sumsq     (sumsq)
	);

	rm2q_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_a),
		.in_side   (side_a),
		.sumsq     (sumsq),
		.out_valid (v_b),
		.out_side  (side_b),
		.root      (norm)
	);

	rm2q_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (v_b),
		.in_side    (side_b),
		.norm       (norm),
		.out_valid  (m_tvalid),
		.quat       (quat),
		.branch     (branch),
		.degenerate (degenerate)
	);

	assign m_tdata = {quat[3], quat[2], quat[1], quat[0]};
	assign m_tuser = {degenerate, branch};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata[15:0] == ONE && m_tdata[63:16] == '0)
		else $error("degenerate result is not identity");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

// File: hw/rtl/rm2q_prep.sv
// Front stages: branch choice, quaternion vector, squares and sum of squares.
// Depends on rm2q_pkg.
module rm2q_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_valid,
	input  logic [8:0][rm2q_pkg::W-1:0]         m,
	output logic                                out_valid,
	output rm2q_pkg::side_t                     side,
	output logic [rm2q_pkg::SW-1:0]             sumsq
);
	import rm2q_pkg::*;

	localparam logic signed [MW:0] ONE_E = (MW+1)'(ONE);

	logic signed [MW:0] e [9];
	logic signed [MW:0] tr;
	logic signed [MW:0] comp [4];
	logic signed [MW:0] r;
	branch_t br;

	logic               v_s1, v_s2, v_s3;
	logic signed [MW:0] comp_s1 [4];
	branch_t            br_s1;
	logic               rpos_s1;
	logic [2*MW-1:0]    sq_s2 [4];
	side_t              side_s2, side_s3;
	logic [SW-1:0]      sum_s3;
	logic [MW:0]        ab [4];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			e[i] = {{2{m[i][W-1]}}, m[i]};
		end
		tr = e[0] + e[4] + e[8];
		if (tr > 0) begin
			br = BR_TRACE;
			r = ONE_E + tr;
			comp[0] = r;
			comp[1] = e[7] - e[5];
			comp[2] = e[2] - e[6];
			comp[3] = e[3] - e[1];
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			br = BR_X;
			r = ONE_E + e[0] - e[4] - e[8];
			comp[0] = e[7] - e[5];
			comp[1] = r;
			comp[2] = e[1] + e[3];
			comp[3] = e[2] + e[6];
		end else if (e[4] > e[8]) begin
			br = BR_Y;
			r = ONE_E + e[4] - e[0] - e[8];
			comp[0] = e[2] - e[6];
			comp[1] = e[1] + e[3];
			comp[2] = r;
			comp[3] = e[5] + e[7];
		end else begin
			br = BR_Z;
			r = ONE_E + e[8] - e[0] - e[4];
			comp[0] = e[3] - e[1];
			comp[1] = e[2] + e[6];
			comp[2] = e[5] + e[7];
			comp[3] = r;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ab[i] = comp_s1[i][MW] ? MW'(0) - comp_s1[i] : comp_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				comp_s1[i]      <= comp[i];
				side_s2.mag[i]  <= ab[i][MW-1:0];
				side_s2.neg[i]  <= comp_s1[i][MW];
				sq_s2[i]        <= ab[i][MW-1:0] * ab[i][MW-1:0];
			end
			br_s1          <= br;
			rpos_s1        <= (r > 0);
			side_s2.branch <= br_s1;
			side_s2.rpos   <= rpos_s1;
			side_s3        <= side_s2;
			sum_s3         <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]) + SW'(sq_s2[3]);
		end
	end

	assign out_valid = v_s3;
	assign side      = side_s3;
	assign sumsq     = sum_s3;

endmodule

// File: hw/rtl/rm2q_sqrt.sv
// Pipelined integer square root, one root bit per stage, sideband carried along.
// Depends on rm2q_pkg.
module rm2q_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  rm2q_pkg::side_t         in_side,
	input  logic [rm2q_pkg::SW-1:0] sumsq,
	output logic                    out_valid,
	output rm2q_pkg::side_t         out_side,
	output logic [rm2q_pkg::RW-1:0] root
);
	import rm2q_pkg::*;

	logic [SW-1:0] rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic          vld_s  [RW+1];
	side_t         side_s [RW+1];

	assign rem_s[0]  = sumsq;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int K = RW - 1 - i;
		logic [SW-1:0] cand;
		logic          take;

		assign cand = (SW'(root_s[i]) << (K + 1)) | (SW'(1) << (2 * K));
		assign take = (rem_s[i] >= cand);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= take ? rem_s[i] - cand : rem_s[i];
				root_s[i+1] <= take ? (root_s[i] | (RW'(1) << K)) : root_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_side  = side_s[RW];
	assign root      = root_s[RW];

endmodule

// File: hw/rtl/rm2q_div.sv
// Four-lane pipelined rounding divider, sign restore, saturation, identity fallback.
// Depends on rm2q_pkg.
module rm2q_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  rm2q_pkg::side_t              in_side,
	input  logic [rm2q_pkg::RW-1:0]      norm,
	output logic                         out_valid,
	output logic [3:0][rm2q_pkg::W-1:0]  quat,
	output rm2q_pkg::branch_t            branch,
	output logic                         degenerate
);
	import rm2q_pkg::*;

	localparam logic signed [W:0] SMAX = (W+1)'((1 << (W - 1)) - 1);
	localparam logic signed [W:0] SMIN = -SMAX - (W+1)'(1);

	logic [3:0][NW-1:0] rem_s  [QW+1];
	logic [3:0][QW-1:0] q_s    [QW+1];
	logic [RW-1:0]      n_s    [QW+1];
	logic               vld_s  [QW+1];
	logic [3:0]         neg_s  [QW+1];
	branch_t            br_s   [QW+1];
	logic               deg_s  [QW+1];

	logic               vld_q;
	logic [3:0][W-1:0]  quat_q;
	branch_t            br_q;
	logic               deg_q;
	logic signed [W:0]  sv [4];
	logic signed [W:0]  sat [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				rem_s[0][j] <= (NW'(in_side.mag[j]) << F) + NW'(norm >> 1);
			end
			q_s[0]   <= '0;
			n_s[0]   <= norm;
			neg_s[0] <= in_side.neg;
			br_s[0]  <= in_side.branch;
			deg_s[0] <= !in_side.rpos || (norm == '0);
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int K = QW - 1 - i;
		logic [NW:0] d;

		assign d = (NW+1)'(n_s[i]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < 4; j++) begin
					if ({1'b0, rem_s[i][j]} >= d) begin
						rem_s[i+1][j] <= NW'({1'b0, rem_s[i][j]} - d);
						q_s[i+1][j]   <= q_s[i][j] | (QW'(1) << K);
					end else begin
						rem_s[i+1][j] <= rem_s[i][j];
						q_s[i+1][j]   <= q_s[i][j];
					end
				end
				n_s[i+1]   <= n_s[i];
				neg_s[i+1] <= neg_s[i];
				br_s[i+1]  <= br_s[i];
				deg_s[i+1] <= deg_s[i];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sv[j] = neg_s[QW][j] ? -$signed((W+1)'(q_s[QW][j])) : $signed((W+1)'(q_s[QW][j]));
			if (sv[j] > SMAX) begin
				sat[j] = SMAX;
			end else if (sv[j] < SMIN) begin
				sat[j] = SMIN;
			end else begin
				sat[j] = sv[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				if (deg_s[QW]) begin
					quat_q[j] <= (j == 0) ? ONE : '0;
				end else begin
					quat_q[j] <= sat[j][W-1:0];
				end
			end
			br_q  <= br_s[QW];
			deg_q <= deg_s[QW];
		end
	end

	assign out_valid  = vld_q;
	assign quat       = quat_q;
	assign branch     = br_q;
	assign degenerate = deg_q;

endmodule

// File: test/tb_rotation_matrix_to_quaternion.sv
// Self-checking bench for rotation_matrix_to_quaternion: directed matrices, then random ones.
// Builds the expected quaternion, branch and degenerate flag with its own integer converter, except for fixed rows.
// Depends on rm2q_pkg and the RTL under hw/rtl.
module tb_rotation_matrix_to_quaternion;
	timeunit 1ns;
	timeprecision 1ps;
	import rm2q_pkg::*;

	typedef struct {
		logic [15:0] w, x, y, z;
		branch_t     br;
		logic        degen;
	} quat_t;

	typedef struct {
		logic [143:0] mat;
		bit           fixed;
		quat_t        q;
	} row_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [63:0]  m_tdata;
	logic [2:0]   m_tuser;

	quat_t quat_queue[$];
	int    errors = 0;
	int    sent = 0;
	int    got = 0;
	int    hold_rx = 0;
	int    branch_seen[4];

	rotation_matrix_to_quaternion uut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("rotation_matrix_to_quaternion regression: fail");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] sat16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic quat_t matrix_to_quat(logic [143:0] d);
		longint m[9];
		longint vec[4];
		longint unsigned mag[4];
		longint unsigned maxm, sumsq, n, v;
		longint one, tr, r;
		logic [15:0] o[4];
		int sh;
		quat_t q;
		for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
		one = 64'd1 << 14;
		tr = m[0] + m[4] + m[8];
		if (tr > 0) begin
			q.br = BR_TRACE;
			r = one + tr;
			vec = '{r, m[7] - m[5], m[2] - m[6], m[3] - m[1]};
		end else if (m[0] > m[4] && m[0] > m[8]) begin
			q.br = BR_X;
			r = one + m[0] - m[4] - m[8];
			vec = '{m[7] - m[5], r, m[1] + m[3], m[2] + m[6]};
		end else if (m[4] > m[8]) begin
			q.br = BR_Y;
			r = one + m[4] - m[0] - m[8];
			vec = '{m[2] - m[6], m[1] + m[3], r, m[5] + m[7]};
		end else begin
			q.br = BR_Z;
			r = one + m[8] - m[0] - m[4];
			vec = '{m[3] - m[1], m[2] + m[6], m[5] + m[7], r};
		end
		maxm = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = vec[i] < 0 ? -vec[i] : vec[i];
			if (mag[i] > maxm) maxm = mag[i];
		end
		sh = 0;
		while ((maxm >> sh) >= (64'd1 << 31)) sh++;
		sumsq = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] >>= sh;
			sumsq += mag[i] * mag[i];
		end
		n = int_sqrt(sumsq);
		if (r <= 0 || n == 0) begin
			q.w = ONE;
			q.x = '0;
			q.y = '0;
			q.z = '0;
			q.degen = 1;
			return q;
		end
		for (int i = 0; i < 4; i++) begin
			v = (mag[i] * longint'(one) + (n >> 1)) / n;
			o[i] = sat16(vec[i] < 0 ? -longint'(v) : longint'(v));
		end
		q.w = o[0];
		q.x = o[1];
		q.y = o[2];
		q.z = o[3];
		q.degen = 0;
		return q;
	endfunction

	function automatic logic [143:0] pack_mat(int e[9]);
		logic [143:0] d;
		for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'(e[i]);
		return d;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] act, logic [15:0] exp_v);
		errors++;
		$display("result %0d: %s got %h, want %h", got, what, act, exp_v);
	endtask

	task automatic send_matrix(logic [143:0] d, bit fixed, quat_t q);
		s_tvalid <= 1;
		s_tdata <= d;
		quat_queue.push_back(fixed ? q : matrix_to_quat(d));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic idle_sender();
		s_tvalid <= 0;
		s_tdata <= 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		@(posedge clk);
	endtask

	function automatic logic [143:0] random_rotation();
		int e[9];
		int k, c, s;
		// a signed permutation of axes, lightly perturbed
		k = $urandom_range(0, 5);
		for (int i = 0; i < 9; i++) e[i] = 0;
		for (int i = 0; i < 3; i++) begin
			c = (k < 3) ? (i + k) % 3 : (2 - i + k) % 3;
			s = $urandom_range(0, 1) ? 16384 : -16384;
			e[3*i + c] = s;
		end
		for (int i = 0; i < 9; i++) e[i] += int'($urandom_range(0, 8000)) - 4000;
		return pack_mat(e);
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			quat_t q;
			if (quat_queue.size() == 0) begin
				errors++;
				$display("unexpected result %h %h", m_tdata, m_tuser);
			end else begin
				q = quat_queue.pop_front();
				if (m_tdata[15:0] !== q.w) report_mismatch("w", m_tdata[15:0], q.w);
				if (m_tdata[31:16] !== q.x) report_mismatch("x", m_tdata[31:16], q.x);
				if (m_tdata[47:32] !== q.y) report_mismatch("y", m_tdata[47:32], q.y);
				if (m_tdata[63:48] !== q.z) report_mismatch("z", m_tdata[63:48], q.z);
				if (m_tuser[1:0] !== q.br) report_mismatch("branch", m_tuser[1:0], q.br);
				if (m_tuser[2] !== q.degen) report_mismatch("degenerate", m_tuser[2], q.degen);
				branch_seen[q.br]++;
			end
			got++;
		end
	end

	// receiver: always ready for the first 300 results, then a random stall pattern; long hold-off on request
	always @(posedge clk) begin
		if (hold_rx > 0) begin
			hold_rx <= hold_rx - 1;
			m_tready <= 0;
		end else if (got < 300) begin
			m_tready <= 1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		row_t rows[$];
		quat_t id_q, z_q;
		int burst, wait_n;
		id_q = '{ONE, 16'd0, 16'd0, 16'd0, BR_TRACE, 1'b0};
		z_q = '{16'd0, 16'd0, 16'd0, 16'h4000, BR_Z, 1'b0};
		rows.push_back('{pack_mat('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}), 1, id_q});
		rows.push_back('{pack_mat('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}), 1, z_q});
		rows.push_back('{pack_mat('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}), 0, id_q});
		rows.push_back('{pack_mat('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}), 0, id_q});
		rows.push_back('{'0, 0, id_q});
		rows.push_back('{'1, 0, id_q});
		rows.push_back('{{9{16'h8000}}, 0, id_q});
		rows.push_back('{{9{16'h7fff}}, 0, id_q});
		rows.push_back('{{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 0, id_q});
		rows.push_back('{{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 0, id_q});
		rows.push_back('{pack_mat('{0, 0, 0, 0, 0, 0, 0, 0, 0}), 0, id_q});
		rows.push_back('{pack_mat('{5, 0, 0, 0, 5, 0, 0, 0, 0}), 0, id_q});
		rows.push_back('{pack_mat('{-5, 0, 0, 0, 3, 0, 0, 0, 3}), 0, id_q});
		rows.push_back('{pack_mat('{-9, 1, 2, 3, 4, 5, 6, 7, -9}), 0, id_q});
		rows.push_back('{pack_mat('{0, 16384, 0, -16384, 0, 0, 0, 0, 16384}), 0, id_q});
		rows.push_back('{pack_mat('{-100, 7, -3, 2, -200, 9, 1, 4, -300}), 0, id_q});
		rows.push_back('{pack_mat('{-1, 0, 0, 0, 0, 0, 0, 0, 0}), 0, id_q});

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) send_matrix(rows[i].mat, rows[i].fixed, rows[i].q);
		idle_sender();
		while (quat_queue.size() != 0) @(posedge clk);
		hold_rx = 200;
		for (int i = 0; i < 120; i++) send_matrix(random_rotation(), 0, id_q);
		idle_sender();
		while (quat_queue.size() != 0) @(posedge clk);
		while (sent < 2000) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(0, 9) < 7) send_matrix(random_rotation(), 0, id_q);
				else send_matrix(144'({$urandom, $urandom, $urandom, $urandom, $urandom}),
					0, id_q);
			end
			wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			repeat (wait_n) idle_sender();
		end
		idle_sender();
		while (quat_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d matrices sent, %0d quaternions checked", sent, got);
		$display("branches trace/x/y/z: %0d/%0d/%0d/%0d", branch_seen[0], branch_seen[1],
			branch_seen[2], branch_seen[3]);
		if (errors == 0) $display("rotation_matrix_to_quaternion regression: pass");
		else $display("rotation_matrix_to_quaternion regression: fail");
		$finish;
	end
endmodule
